### hw/rtl/rational_arithmetic_reduce_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the rational arithmetic block.
// Shared forms for the concurrent checks of the RTL.
// ----------------------------------------------------------------------------
`ifndef RATIONAL_ARITHMETIC_REDUCE_MACROS_SVH
`define RATIONAL_ARITHMETIC_REDUCE_MACROS_SVH

// An implication checked on every clock edge outside reset.
`define RAR_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// An implication whose consequent is checked in the cycle after its antecedent.
`define RAR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

### hw/rtl/rar_pkg.sv
// ----------------------------------------------------------------------------
// Rational arithmetic package
// Widths and operation codes shared by the interfaces and the RTL.
// ----------------------------------------------------------------------------
package rar_pkg;

    localparam int OPERAND_WIDTH_DEF = 16;
    localparam int IN_W  = 16;
    localparam int NUM_W = 33;
    localparam int DEN_W = 31;

    localparam logic [1:0] OP_ADD = 2'd0;
    localparam logic [1:0] OP_SUB = 2'd1;
    localparam logic [1:0] OP_MUL = 2'd2;
    localparam logic [1:0] OP_DIV = 2'd3;

    localparam logic STATUS_OK  = 1'b0;
    localparam logic STATUS_ERR = 1'b1;

endpackage

### hw/rtl/rar_if.sv
// ----------------------------------------------------------------------------
// Rational arithmetic channels
// Valid/ready channels for operand beats and result beats.
// ----------------------------------------------------------------------------
interface rar_in_if
    import rar_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [1:0]        op;
    logic [IN_W-1:0]   a_num;
    logic [IN_W-1:0]   a_den;
    logic [IN_W-1:0]   b_num;
    logic [IN_W-1:0]   b_den;

    modport source (output valid, op, a_num, a_den, b_num, b_den, input ready);
    modport sink   (input valid, op, a_num, a_den, b_num, b_den, output ready);
endinterface

interface rar_out_if
    import rar_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [NUM_W-1:0]  res_num;
    logic [DEN_W-1:0]  res_den;
    logic              status;

    modport source (output valid, res_num, res_den, status, input ready);
    modport sink   (input valid, res_num, res_den, status, output ready);
endinterface

### hw/rtl/rational_arithmetic_reduce.sv
// ----------------------------------------------------------------------------
// Rational arithmetic with reduction
// Adds, subtracts, multiplies or divides two fractions and reduces the result.
// ----------------------------------------------------------------------------
// One beat is handled at a time. After acceptance the block steps through
// the states M0, M1 (add and subtract only), M2 and M3 for operand setup and
// cross products through one shared multiplier. Then one shared restoring
// divider of one quotient bit a cycle runs the Euclidean loop, one division
// per remainder step, and the two final divisions by the greatest common
// divisor before the result is offered. Errors finish at once.
// The result is held in an output register until taken.
`include "rational_arithmetic_reduce_macros.svh"

module rational_arithmetic_reduce
    import rar_pkg::*;
#(
    parameter int OPERAND_WIDTH = OPERAND_WIDTH_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    rar_in_if.sink     in_ch,
    rar_out_if.source  out_ch
);

    localparam int W  = OPERAND_WIDTH;
    localparam int PW = 2 * W + 1;
    localparam int CW = $clog2(PW + 1);

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_M0   = 4'd1;
    localparam logic [3:0] S_M1   = 4'd2;
    localparam logic [3:0] S_M2   = 4'd3;
    localparam logic [3:0] S_M3   = 4'd4;
    localparam logic [3:0] S_GCD  = 4'd5;
    localparam logic [3:0] S_DN   = 4'd6;
    localparam logic [3:0] S_DD   = 4'd7;
    localparam logic [3:0] S_OUT  = 4'd8;

    logic [3:0]    state_reg;
    logic [1:0]    op_reg;
    logic [W-1:0]  an_reg, ad_reg, bn_reg, bd_reg;
    logic          ans_reg, ads_reg, bns_reg, bds_reg;
    logic [PW-1:0] p_reg;
    logic          ps_reg;
    logic [PW-1:0] num_reg, den_reg;
    logic          nneg_reg, dneg_reg;
    logic [PW-1:0] x_reg, y_reg;
    logic [PW-1:0] dq_reg, drem_reg, ddiv_reg;
    logic [CW-1:0] cnt_reg;
    logic          busy_div_reg;

    logic [NUM_W-1:0] res_num_reg;
    logic [DEN_W-1:0] res_den_reg;
    logic             status_reg;
    logic             ovalid_reg;

    // Shared multiplier operands.
    logic [W-1:0]    mul_a, mul_b;
    logic [2*W-1:0]  mul_p;

    function automatic logic [W-1:0] mag_of(input logic [IN_W-1:0] raw);
        logic [W-1:0] v;
        begin
            v = W'(raw);
            mag_of = v[W-1] ? (~v + 1'b1) : v;
        end
    endfunction

    function automatic logic sign_of(input logic [IN_W-1:0] raw);
        logic [W-1:0] v;
        begin
            v = W'(raw);
            sign_of = v[W-1];
        end
    endfunction

    always_comb
    begin
        unique case (state_reg)
            S_M0:    begin mul_a = an_reg; mul_b = (op_reg == OP_MUL) ? bn_reg : bd_reg; end
            S_M1:    begin mul_a = bn_reg; mul_b = ad_reg; end
            S_M2:    begin mul_a = ad_reg; mul_b = (op_reg == OP_DIV) ? bn_reg : bd_reg; end
            default: begin mul_a = an_reg; mul_b = bd_reg; end
        endcase
        mul_p = mul_a * mul_b;
    end

    // One restoring divider step: remainder shifted in, quotient bit out.
    logic [PW:0]   trial;
    logic [PW-1:0] rem_sh;
    always_comb
    begin
        rem_sh = {drem_reg[PW-2:0], dq_reg[PW-1]};
        trial  = {1'b0, rem_sh} - {1'b0, ddiv_reg};
    end

    logic in_fire;
    logic zero_err;
    assign in_fire = in_ch.valid && in_ch.ready;
    assign in_ch.ready = (state_reg == S_IDLE) && !ovalid_reg;
    assign zero_err = (mag_of(in_ch.a_den) == '0) || (mag_of(in_ch.b_den) == '0)
                   || ((in_ch.op == OP_DIV) && (mag_of(in_ch.b_num) == '0));

    logic [PW-1:0] t_mag;
    logic          t_neg, s_neg;
    logic [PW-1:0] sum_mag;
    logic          sum_neg;
    always_comb
    begin
        t_mag = PW'(mul_p);
        t_neg = (mul_p != '0) && (bns_reg != ads_reg);
        if (op_reg == OP_SUB && t_mag != '0)
        begin
            t_neg = !t_neg;
        end
        s_neg = ps_reg;
        if (s_neg == t_neg)
        begin
            sum_mag = p_reg + t_mag;
            sum_neg = s_neg;
        end
        else if (p_reg >= t_mag)
        begin
            sum_mag = p_reg - t_mag;
            sum_neg = s_neg;
        end
        else
        begin
            sum_mag = t_mag - p_reg;
            sum_neg = t_neg;
        end
        if (sum_mag == '0)
        begin
            sum_neg = 1'b0;
        end
    end

    logic res_neg;
    assign res_neg = (dq_reg != '0) && (nneg_reg != dneg_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            ovalid_reg   <= 1'b0;
            busy_div_reg <= 1'b0;
        end
        else
        begin
            if (out_ch.valid && out_ch.ready)
            begin
                ovalid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_fire)
                    begin
                        if (zero_err)
                        begin
                            res_num_reg <= '0;
                            res_den_reg <= '0;
                            status_reg  <= STATUS_ERR;
                            ovalid_reg  <= 1'b1;
                        end
                        else
                        begin
                            state_reg <= S_M0;
                        end
                    end
                end
                S_M0:
                begin
                    p_reg  <= PW'(mul_p);
                    ps_reg <= (mul_p != '0) && (ans_reg !=
                              ((op_reg == OP_MUL) ? bns_reg : bds_reg));
                    state_reg <= (op_reg == OP_ADD || op_reg == OP_SUB) ? S_M1 : S_M2;
                end
                S_M1:
                begin
                    p_reg     <= sum_mag;
                    ps_reg    <= sum_neg;
                    state_reg <= S_M2;
                end
                S_M2:
                begin
                    num_reg  <= p_reg;
                    nneg_reg <= ps_reg;
                    den_reg  <= PW'(mul_p);
                    dneg_reg <= ads_reg != ((op_reg == OP_DIV) ? bns_reg : bds_reg);
                    x_reg    <= p_reg;
                    y_reg    <= PW'(mul_p);
                    state_reg <= S_M3;
                end
                S_M3:
                begin
                    busy_div_reg <= 1'b0;
                    state_reg    <= S_GCD;
                end
                S_GCD:
                begin
                    if (!busy_div_reg)
                    begin
                        if (y_reg == '0)
                        begin
                            ddiv_reg     <= (x_reg == '0) ? PW'(1) : x_reg;
                            dq_reg       <= num_reg;
                            drem_reg     <= '0;
                            cnt_reg      <= '0;
                            state_reg    <= S_DN;
                        end
                        else
                        begin
                            ddiv_reg     <= y_reg;
                            dq_reg       <= x_reg;
                            drem_reg     <= '0;
                            cnt_reg      <= '0;
                            busy_div_reg <= 1'b1;
                        end
                    end
                    else if (cnt_reg == CW'(PW))
                    begin
                        x_reg        <= y_reg;
                        y_reg        <= drem_reg;
                        busy_div_reg <= 1'b0;
                    end
                    else
                    begin
                        drem_reg <= trial[PW] ? rem_sh : trial[PW-1:0];
                        dq_reg   <= {dq_reg[PW-2:0], !trial[PW]};
                        cnt_reg  <= cnt_reg + 1'b1;
                    end
                end
                S_DN:
                begin
                    if (cnt_reg == CW'(PW))
                    begin
                        res_num_reg <= res_neg ? NUM_W'(-$signed({1'b0, dq_reg}))
                                               : NUM_W'(dq_reg);
                        dq_reg   <= den_reg;
                        drem_reg <= '0;
                        cnt_reg  <= '0;
                        state_reg <= S_DD;
                    end
                    else
                    begin
                        drem_reg <= trial[PW] ? rem_sh : trial[PW-1:0];
                        dq_reg   <= {dq_reg[PW-2:0], !trial[PW]};
                        cnt_reg  <= cnt_reg + 1'b1;
                    end
                end
                S_DD:
                begin
                    if (cnt_reg == CW'(PW))
                    begin
                        res_den_reg <= DEN_W'(dq_reg);
                        status_reg  <= STATUS_OK;
                        state_reg   <= S_OUT;
                    end
                    else
                    begin
                        drem_reg <= trial[PW] ? rem_sh : trial[PW-1:0];
                        dq_reg   <= {dq_reg[PW-2:0], !trial[PW]};
                        cnt_reg  <= cnt_reg + 1'b1;
                    end
                end
                S_OUT:
                begin
                    ovalid_reg <= 1'b1;
                    state_reg  <= S_IDLE;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            op_reg  <= in_ch.op;
            an_reg  <= mag_of(in_ch.a_num);
            ad_reg  <= mag_of(in_ch.a_den);
            bn_reg  <= mag_of(in_ch.b_num);
            bd_reg  <= mag_of(in_ch.b_den);
            ans_reg <= sign_of(in_ch.a_num) && (mag_of(in_ch.a_num) != '0);
            ads_reg <= sign_of(in_ch.a_den);
            bns_reg <= sign_of(in_ch.b_num) && (mag_of(in_ch.b_num) != '0);
            bds_reg <= sign_of(in_ch.b_den);
        end
    end

    assign out_ch.valid   = ovalid_reg;
    assign out_ch.res_num = res_num_reg;
    assign out_ch.res_den = res_den_reg;
    assign out_ch.status  = status_reg;

    `RAR_ASSERT_IMP(a_ready_idle, clk, rst_n, in_ch.ready, state_reg == S_IDLE)
    `RAR_ASSERT_IMP(a_no_ready_out, clk, rst_n, ovalid_reg, !in_ch.ready)
    `RAR_ASSERT_NEXT(a_err_out, clk, rst_n, in_fire && zero_err, ovalid_reg && status_reg == STATUS_ERR)
    `RAR_ASSERT_IMP(a_ok_den, clk, rst_n, ovalid_reg && status_reg == STATUS_OK, res_den_reg != '0)

endmodule

### verif/tb_rational_arithmetic_reduce.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Testbench for the rational arithmetic block
// Drives operand beats through a valid/ready channel and predicts each reduced
// fraction in a scoreboard. Each result beat is compared field by field with
// the oldest prediction. Random idling and stalls run in several phases.
// ----------------------------------------------------------------------------
module tb_rational_arithmetic_reduce;
    import rar_pkg::*;

    localparam int LIMIT_CYCLES = 20000000;
    localparam int TAIL_CYCLES  = 400;

    typedef struct {
        logic [NUM_W-1:0] num;
        logic [DEN_W-1:0] den;
        logic             status;
    } frac_result_t;

    class frac_scoreboard;
        frac_result_t expected_fracs[$];
        int           mismatches;

        function new();
            mismatches = 0;
        endfunction

        function longint unsigned gcd_of(longint unsigned x, longint unsigned y);
            longint unsigned t;
            while (y != 0)
            begin
                t = x % y;
                x = y;
                y = t;
            end
            return x;
        endfunction

        function void note_operands(logic [1:0] op, logic [IN_W-1:0] an,
                                    logic [IN_W-1:0] ad, logic [IN_W-1:0] bn,
                                    logic [IN_W-1:0] bd);
            frac_result_t    r;
            longint          san, sad, sbn, sbd, num, den;
            longint unsigned nmag, dmag, g;
            logic            neg;
            san = longint'($signed(an));
            sad = longint'($signed(ad));
            sbn = longint'($signed(bn));
            sbd = longint'($signed(bd));
            if (sad == 0 || sbd == 0 || (op == OP_DIV && sbn == 0))
            begin
                r.num = '0;
                r.den = '0;
                r.status = STATUS_ERR;
            end
            else
            begin
                case (op)
                    OP_ADD: begin num = san * sbd + sbn * sad; den = sad * sbd; end
                    OP_SUB: begin num = san * sbd - sbn * sad; den = sad * sbd; end
                    OP_MUL: begin num = san * sbn; den = sad * sbd; end
                    default: begin num = san * sbd; den = sad * sbn; end
                endcase
                nmag = (num < 0) ? -num : num;
                dmag = (den < 0) ? -den : den;
                g = gcd_of(nmag, dmag);
                if (g == 0)
                    g = 1;
                nmag = nmag / g;
                dmag = dmag / g;
                neg = (nmag != 0) && ((num < 0) != (den < 0));
                r.num = neg ? NUM_W'(-nmag) : NUM_W'(nmag);
                r.den = DEN_W'(dmag);
                r.status = STATUS_OK;
            end
            expected_fracs.push_back(r);
        endfunction

        task report(string what, longint unsigned exp_v, longint unsigned got_v);
            $display("MISMATCH %s: expected 0x%0h, got 0x%0h at %0t", what, exp_v,
                     got_v, $realtime);
            mismatches++;
        endtask

        task check_result(logic [NUM_W-1:0] num, logic [DEN_W-1:0] den, logic status);
            frac_result_t e;
            if (expected_fracs.size() == 0)
            begin
                report("unexpected result beat", 0, num);
                return;
            end
            e = expected_fracs.pop_front();
            if (status !== e.status)
                report("status", e.status, status);
            if (num !== e.num)
                report("res_num", e.num, num);
            if (den !== e.den)
                report("res_den", e.den, den);
        endtask
    endclass

    logic clk;
    logic rst_n;
    int   cycles;
    int   gap_pct;
    int   stall_pct;
    int   hold_left;
    frac_scoreboard sb;

    rar_in_if  in_ch();
    rar_out_if out_ch();

    rational_arithmetic_reduce dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch.sink),
        .out_ch (out_ch.source)
    );

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > LIMIT_CYCLES)
        begin
            $display("tb_rational_arithmetic_reduce: done, errors");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && in_ch.valid && in_ch.ready)
            sb.note_operands(in_ch.op, in_ch.a_num, in_ch.a_den, in_ch.b_num, in_ch.b_den);
        if (rst_n && out_ch.valid && out_ch.ready)
            sb.check_result(out_ch.res_num, out_ch.res_den, out_ch.status);
    end

    // The receiver either holds off for a counted stretch or stalls at random.
    always @(negedge clk)
    begin
        if (hold_left > 0)
        begin
            out_ch.ready = 1'b0;
            hold_left--;
        end
        else
            out_ch.ready = ($urandom_range(99) >= stall_pct);
    end

    task send_beat(logic [1:0] op, logic [15:0] an, logic [15:0] ad,
                   logic [15:0] bn, logic [15:0] bd);
        bit placed;
        placed = 0;
        while (!placed)
        begin
            @(negedge clk);
            if ($urandom_range(99) < gap_pct)
                in_ch.valid = 1'b0;
            else
            begin
                in_ch.valid = 1'b1;
                in_ch.op    = op;
                in_ch.a_num = an;
                in_ch.a_den = ad;
                in_ch.b_num = bn;
                in_ch.b_den = bd;
                placed = 1;
            end
        end
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
    endtask

    task go_idle();
        @(negedge clk);
        in_ch.valid = 1'b0;
    endtask

    task drain();
        while (sb.expected_fracs.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
    endtask

    function logic [15:0] pick_operand(bit is_den);
        int r;
        r = $urandom_range(99);
        if (r < 5)
            return is_den ? 16'h0000 : 16'(-$urandom_range(1, 3));
        if (r < 70)
            return 16'($signed($urandom_range(40)) - 20);
        return 16'($urandom);
    endfunction

    task send_random(int count);
        logic [15:0] an, ad, bn, bd;
        for (int i = 0; i < count; i++)
        begin
            an = pick_operand(0);
            ad = pick_operand(1);
            bn = pick_operand(0);
            bd = pick_operand(1);
            // Most beats carry nonzero denominators so the reduction path runs.
            if ($urandom_range(99) < 92)
            begin
                if (ad == 0) ad = 16'd7;
                if (bd == 0) bd = 16'hfffd;
            end
            send_beat(2'($urandom_range(3)), an, ad, bn, bd);
        end
    endtask

    initial
    begin
        sb = new();
        cycles = 0;
        gap_pct = 0;
        stall_pct = 0;
        hold_left = 0;
        rst_n = 1'b0;
        in_ch.valid = 1'b0;
        in_ch.op = OP_ADD;
        in_ch.a_num = '0;
        in_ch.a_den = '0;
        in_ch.b_num = '0;
        in_ch.b_den = '0;
        out_ch.ready = 1'b0;
        repeat (12) @(negedge clk);
        rst_n = 1'b1;

        send_beat(OP_ADD, 16'd1, 16'd2, 16'd1, 16'd3);
        send_beat(OP_SUB, 16'd1, 16'd2, 16'd1, 16'd2);
        send_beat(OP_MUL, 16'd6, 16'hfffc, 16'd2, 16'd9);
        send_beat(OP_DIV, 16'd3, 16'd4, 16'hfffe, 16'd8);
        send_beat(OP_ADD, 16'h8000, 16'h8000, 16'h8000, 16'h8000);
        send_beat(OP_SUB, 16'h7fff, 16'h8000, 16'h8000, 16'h7fff);
        send_beat(OP_MUL, 16'h8000, 16'd1, 16'h8000, 16'd1);
        send_beat(OP_DIV, 16'h8000, 16'd1, 16'd1, 16'h8000);
        send_beat(OP_MUL, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff);
        send_beat(OP_ADD, 16'h7fff, 16'd1, 16'h7fff, 16'd1);
        send_beat(OP_ADD, 16'hffff, 16'd1, 16'hffff, 16'h8000);
        send_beat(OP_ADD, 16'd1, 16'd0, 16'd1, 16'd1);
        send_beat(OP_MUL, 16'd1, 16'd1, 16'd1, 16'd0);
        send_beat(OP_DIV, 16'd5, 16'd3, 16'd0, 16'd7);
        send_beat(OP_DIV, 16'd0, 16'd3, 16'd0, 16'd0);
        send_beat(OP_SUB, 16'd0, 16'd0, 16'd0, 16'd0);
        send_beat(OP_MUL, 16'd0, 16'hfff9, 16'd5, 16'd3);
        send_beat(OP_DIV, 16'd0, 16'd2, 16'hfffb, 16'hfffe);
        send_beat(OP_SUB, 16'hfffd, 16'hfffe, 16'd3, 16'd2);
        send_beat(OP_DIV, 16'hfff1, 16'hfff6, 16'hfffb, 16'hfffc);
        send_beat(OP_ADD, 16'hffff, 16'hffff, 16'hffff, 16'hffff);
        go_idle();
        drain();

        send_random(160);

        gap_pct = 64;
        send_random(160);
        go_idle();
        drain();

        gap_pct = 0;
        stall_pct = 64;
        send_random(160);

        hold_left = 4000;
        gap_pct = 0;
        stall_pct = 0;
        send_random(4);
        go_idle();
        drain();

        gap_pct = 10;
        stall_pct = 10;
        send_random(160);
        go_idle();
        drain();

        if (sb.mismatches == 0 && sb.expected_fracs.size() == 0)
            $display("tb_rational_arithmetic_reduce: done, clean");
        else
            $display("tb_rational_arithmetic_reduce: done, errors");
        $finish;
    end
endmodule
